### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### rtl/core/pavq_pkg.sv
// ----------------------------------------------------------------------------
// Pitch average note quantizer package
// Field widths, note numbering and the quarter-tone band tables in Q12.4 Hz.
// ----------------------------------------------------------------------------
package pavq_pkg;

  localparam int unsigned PITCH_W = 16;
  localparam int unsigned KEY_W   = 7;
  localparam int unsigned FREQ_W  = 15;
  localparam int unsigned NOTE_TABLE_SIZE = 49;

  typedef logic [PITCH_W-1:0] pitch_t;
  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [FREQ_W-1:0]  freq_t;

  localparam key_t KEY_BASE = 7'd36;

  localparam pitch_t BAND_LO [NOTE_TABLE_SIZE] = '{
    16'd1017,  16'd1078,  16'd1142,  16'd1210,  16'd1282,  16'd1358,  16'd1438,
    16'd1524,  16'd1614,  16'd1710,  16'd1812,  16'd1920,  16'd2034,  16'd2155,
    16'd2283,  16'd2419,  16'd2562,  16'd2715,  16'd2876,  16'd3047,  16'd3228,
    16'd3420,  16'd3624,  16'd3839,  16'd4067,  16'd4309,  16'd4565,  16'd4837,
    16'd5124,  16'd5429,  16'd5752,  16'd6094,  16'd6456,  16'd6840,  16'd7247,
    16'd7678,  16'd8134,  16'd8618,  16'd9130,  16'd9673,  16'd10248, 16'd10858,
    16'd11503, 16'd12187, 16'd12912, 16'd13680, 16'd14493, 16'd15355, 16'd16268
  };

  localparam pitch_t BAND_HI [NOTE_TABLE_SIZE] = '{
    16'd1077,  16'd1141,  16'd1209,  16'd1280,  16'd1357,  16'd1437,  16'd1523,
    16'd1613,  16'd1709,  16'd1811,  16'd1919,  16'd2033,  16'd2154,  16'd2282,
    16'd2418,  16'd2561,  16'd2714,  16'd2875,  16'd3046,  16'd3227,  16'd3419,
    16'd3623,  16'd3838,  16'd4066,  16'd4308,  16'd4564,  16'd4836,  16'd5123,
    16'd5428,  16'd5751,  16'd6093,  16'd6455,  16'd6839,  16'd7246,  16'd7677,
    16'd8133,  16'd8617,  16'd9129,  16'd9672,  16'd10247, 16'd10857, 16'd11502,
    16'd12186, 16'd12911, 16'd13679, 16'd14492, 16'd15354, 16'd16267, 16'd17234
  };

  localparam freq_t BAND_NOMINAL [NOTE_TABLE_SIZE] = '{
    15'd1047,  15'd1109,  15'd1175,  15'd1244,  15'd1319,  15'd1397,  15'd1480,
    15'd1568,  15'd1661,  15'd1760,  15'd1865,  15'd1976,  15'd2093,  15'd2217,
    15'd2349,  15'd2489,  15'd2637,  15'd2794,  15'd2960,  15'd3136,  15'd3322,
    15'd3520,  15'd3729,  15'd3951,  15'd4186,  15'd4435,  15'd4699,  15'd4978,
    15'd5274,  15'd5588,  15'd5920,  15'd6272,  15'd6645,  15'd7040,  15'd7459,
    15'd7902,  15'd8372,  15'd8870,  15'd9397,  15'd9956,  15'd10548, 15'd11175,
    15'd11840, 15'd12544, 15'd13290, 15'd14080, 15'd14917, 15'd15804, 15'd16744
  };

endpackage

### rtl/core/pavq_if.sv
// ----------------------------------------------------------------------------
// Pitch average note quantizer channels
// Valid/ready channels for pitch estimate requests and note results.
// ----------------------------------------------------------------------------
interface pavq_in_if;
  logic             valid;
  logic             ready;
  pavq_pkg::pitch_t pitch_estimate;

  modport source (output valid, output pitch_estimate, input ready);
  modport sink (input valid, input pitch_estimate, output ready);
endinterface

interface pavq_out_if;
  logic            valid;
  logic            ready;
  pavq_pkg::key_t  note_key;
  pavq_pkg::freq_t note_freq;

  modport source (output valid, output note_key, output note_freq, input ready);
  modport sink (input valid, input note_key, input note_freq, output ready);
endinterface

### rtl/core/pitch_average_note_quantizer.sv
// Throughput: one request per cycle unless the result channel back-pressures,
// through four registered stages (history and sum, reciprocal-multiply
// average, band hit vector, key and frequency).
// Reset: synchronous active-low reset clears the history, the running sum and
// every stage valid; the block accepts requests once reset is released.
// ----------------------------------------------------------------------------
// Pitch average note quantizer
// Averages the recent pitch estimates and quantizes the average to the
// nearest equal-tempered note by quarter-tone bands.
// ----------------------------------------------------------------------------
module pitch_average_note_quantizer #(
  parameter int unsigned HISTORY_DEPTH = 10,
  parameter int unsigned NOTE_COUNT    = 49
) (
  input  logic       clk,
  input  logic       rst_n,
  pavq_in_if.sink    in_ch,
  pavq_out_if.source out_ch
);
  import pavq_pkg::*;

  logic   avg_valid;
  logic   avg_ready;
  pitch_t avg_value;

  pavq_avg #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_avg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_pitch  (in_ch.pitch_estimate),
    .avg_valid (avg_valid),
    .avg_ready (avg_ready),
    .avg_value (avg_value)
  );

  pavq_match #(
    .NOTE_COUNT(NOTE_COUNT)
  ) u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .avg_valid (avg_valid),
    .avg_ready (avg_ready),
    .avg_value (avg_value),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_key   (out_ch.note_key),
    .out_freq  (out_ch.note_freq)
  );

endmodule

### rtl/core/pavq_avg.sv
// ----------------------------------------------------------------------------
// Pitch history averager
// Keeps the last estimates and their running sum, then divides the sum by the
// history depth with a reciprocal multiply into a registered average.
// ----------------------------------------------------------------------------
module pavq_avg #(
  parameter int unsigned HISTORY_DEPTH = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  pavq_pkg::pitch_t in_pitch,
  output logic             avg_valid,
  input  logic             avg_ready,
  output pavq_pkg::pitch_t avg_value
);
  import pavq_pkg::*;

  localparam int unsigned DEPTH_LOG   = $clog2(HISTORY_DEPTH);
  localparam int unsigned SUM_W       = PITCH_W + DEPTH_LOG;
  localparam int unsigned RECIP_W     = SUM_W + 1;
  localparam int unsigned RECIP_SHIFT = SUM_W + DEPTH_LOG;
  localparam int unsigned PROD_W      = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(
    ((64'd1 << RECIP_SHIFT) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH));

  pitch_t             hist_r [HISTORY_DEPTH];
  logic [SUM_W-1:0]   sum_r;
  logic [SUM_W-1:0]   sum_nxt;
  logic               sum_valid_r;
  logic               sum_ready;
  logic               avg_valid_r;
  logic               avg_load;
  pitch_t             avg_r;
  logic [PROD_W-1:0]  prod;

  assign avg_load  = !avg_valid_r || avg_ready;
  assign sum_ready = !sum_valid_r || avg_load;
  assign in_ready  = sum_ready;
  assign avg_valid = avg_valid_r;
  assign avg_value = avg_r;

  assign sum_nxt = sum_r - SUM_W'(hist_r[HISTORY_DEPTH-1]) + SUM_W'(in_pitch);
  assign prod    = {{RECIP_W{1'b0}}, sum_r} * {{SUM_W{1'b0}}, RECIP_C};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_r[i] <= '0;
      end
      sum_r       <= '0;
      sum_valid_r <= 1'b0;
    end else if (sum_ready) begin
      sum_valid_r <= in_valid;
      if (in_valid) begin
        for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
          hist_r[i] <= hist_r[i-1];
        end
        hist_r[0] <= in_pitch;
        sum_r     <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_valid_r <= 1'b0;
    end else if (avg_load) begin
      avg_valid_r <= sum_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (avg_load && sum_valid_r) begin
      avg_r <= prod[RECIP_SHIFT +: PITCH_W];
    end
  end

endmodule

### rtl/core/pavq_match.sv
// ----------------------------------------------------------------------------
// Note band matcher
// Compares the average against every quarter-tone band, keeps the lowest hit
// as a one-hot vector, then looks up the key and nominal frequency.
// ----------------------------------------------------------------------------
module pavq_match #(
  parameter int unsigned NOTE_COUNT = 49
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             avg_valid,
  output logic             avg_ready,
  input  pavq_pkg::pitch_t avg_value,
  output logic             out_valid,
  input  logic             out_ready,
  output pavq_pkg::key_t   out_key,
  output pavq_pkg::freq_t  out_freq
);
  import pavq_pkg::*;

  logic [NOTE_COUNT-1:0] hit;
  logic [NOTE_COUNT-1:0] first_nxt;
  logic [NOTE_COUNT-1:0] first_r;
  logic                  first_valid_r;
  logic                  first_ready;
  logic                  out_load;
  logic                  out_valid_r;
  key_t                  key_nxt;
  key_t                  key_r;
  freq_t                 freq_nxt;
  freq_t                 freq_r;

  assign out_load    = !out_valid_r || out_ready;
  assign first_ready = !first_valid_r || out_load;
  assign avg_ready   = first_ready;
  assign out_valid   = out_valid_r;
  assign out_key     = key_r;
  assign out_freq    = freq_r;

  always_comb begin
    for (int i = 0; i < NOTE_COUNT; i++) begin
      hit[i] = (avg_value >= BAND_LO[i]) && (avg_value <= BAND_HI[i]);
    end
  end

  assign first_nxt = hit & (~hit + NOTE_COUNT'(1));

  always_comb begin
    key_nxt  = '0;
    freq_nxt = '0;
    for (int i = 0; i < NOTE_COUNT; i++) begin
      key_nxt  = key_nxt | ({KEY_W{first_r[i]}} & (KEY_BASE + KEY_W'(i)));
      freq_nxt = freq_nxt | ({FREQ_W{first_r[i]}} & BAND_NOMINAL[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (first_ready) begin
        first_valid_r <= avg_valid;
      end
      if (out_load) begin
        out_valid_r <= first_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (first_ready && avg_valid) begin
      first_r <= first_nxt;
    end
    if (out_load && first_valid_r) begin
      key_r  <= key_nxt;
      freq_r <= freq_nxt;
    end
  end

endmodule

### rtl/core/pavq_checker.sv
// ----------------------------------------------------------------------------
// Pitch average note quantizer checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pavq_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_ready,
  input pavq_pkg::key_t  out_key,
  input pavq_pkg::freq_t out_freq
);
  import pavq_pkg::*;

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_key) && $stable(out_freq))
  `ASSERT_IMPL(a_none_pair, clk, rst_n, out_valid, (out_key == '0) == (out_freq == '0))
  `ASSERT_IMPL(a_key_range, clk, rst_n, out_valid && (out_key != '0), (out_key >= KEY_BASE) && (out_key <= KEY_W'(84)))
  `ASSERT_IMPL(a_freq_range, clk, rst_n, out_valid && (out_key != '0), (out_freq >= BAND_NOMINAL[0]) && (out_freq <= BAND_NOMINAL[NOTE_TABLE_SIZE-1]))

endmodule

bind pitch_average_note_quantizer pavq_checker u_pavq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_key   (out_ch.note_key),
  .out_freq  (out_ch.note_freq)
);

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Pitch average note quantizer testbench
// Drives pitch estimate requests through the valid/ready input channel and
// checks every note result against a cycle-free model of the moving average
// and the quarter-tone band search. Covers band edges, gaps between bands,
// warm-up, output back-pressure and random tone, noise and dropout streams.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pavq_pkg::*;

  localparam int HISTORY_DEPTH = 10;
  localparam int NOTE_COUNT    = 49;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int DRAIN_CYCLES  = 20;

  typedef struct packed {
    key_t  key;
    freq_t freq;
  } note_result_t;

  logic clk;
  logic rst_n;

  pavq_in_if  in_ch ();
  pavq_out_if out_ch ();

  pitch_average_note_quantizer #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .NOTE_COUNT   (NOTE_COUNT)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  pitch_t       pitch_hist [HISTORY_DEPTH];
  logic [19:0]  pitch_sum;
  note_result_t expected_notes [$];
  int           mismatch_count;
  int           cycle_count;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           hold_cycles;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic note_result_t predict_note(input pitch_t sample);
    note_result_t res;
    logic [19:0]  avg;
    res = '0;
    pitch_sum = pitch_sum - 20'(pitch_hist[HISTORY_DEPTH-1]);
    for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
      pitch_hist[i] = pitch_hist[i-1];
    end
    pitch_hist[0] = sample;
    pitch_sum = pitch_sum + 20'(sample);
    avg = pitch_sum / 20'(HISTORY_DEPTH);
    for (int i = 0; i < NOTE_COUNT; i++) begin
      if (20'(BAND_LO[i]) <= avg && avg <= 20'(BAND_HI[i])) begin
        res.key  = KEY_BASE + key_t'(i);
        res.freq = BAND_NOMINAL[i];
        break;
      end
    end
    return res;
  endfunction

  // Picks the estimate that moves the average as close to the target as the
  // 16-bit range allows.
  function automatic pitch_t sample_for_average(input int target);
    int base;
    int s;
    base = int'(pitch_sum) - int'(pitch_hist[HISTORY_DEPTH-1]);
    s = HISTORY_DEPTH * target - base + int'($urandom_range(HISTORY_DEPTH - 1));
    if (s < 0) s = 0;
    if (s > 65535) s = 65535;
    return pitch_t'(s);
  endfunction

  task automatic send_pitch(input pitch_t sample);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.pitch_estimate <= sample;
    do @(posedge clk); while (!in_ch.ready);
    expected_notes.push_back(predict_note(sample));
    @(negedge clk);
  endtask

  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    while (expected_notes.size() != 0) @(negedge clk);
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ch.ready <= (int'($urandom_range(99)) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    note_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_notes.size() == 0) begin
        $display("%0t unexpected result: key %0d freq %0d", $time,
                 out_ch.note_key, out_ch.note_freq);
        mismatch_count++;
      end else begin
        want = expected_notes.pop_front();
        if (out_ch.note_key !== want.key) begin
          $display("%0t note_key mismatch: expected %0d actual %0d", $time,
                   want.key, out_ch.note_key);
          mismatch_count++;
        end
        if (out_ch.note_freq !== want.freq) begin
          $display("%0t note_freq mismatch: expected %0d actual %0d", $time,
                   want.freq, out_ch.note_freq);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_band_edges();
    int targets [8];
    targets = '{1016, 1017, 1077, 1281, 8372, 16268, 17234, 17235};
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_pitch(16'h0000);
    send_pitch(16'hFFFF);
    foreach (targets[i]) begin
      repeat (2) send_pitch(sample_for_average(targets[i]));
    end
    send_pitch(16'hAAAA);
    send_pitch(16'h5555);
    send_pitch(16'hFFFF);
    send_pitch(16'h0000);
    wait_results_drained();
  endtask

  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles   = 150;
    repeat (40) send_pitch(pitch_t'($urandom_range(65535)));
    wait_results_drained();
  endtask

  task automatic test_random_tones(input int send_pct, input int recv_pct,
                                   input int n_items);
    int sent;
    int kind;
    int idx;
    int lo;
    int span;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(9);
      if (kind < 5) begin
        idx  = $urandom_range(NOTE_COUNT - 1);
        lo   = BAND_LO[idx];
        span = BAND_HI[idx] - BAND_LO[idx];
        repeat ($urandom_range(20, 5)) begin
          if ($urandom_range(15) == 0) begin
            send_pitch('0);
          end else begin
            send_pitch(pitch_t'(lo - 8 + int'($urandom_range(span + 16))));
          end
          sent++;
        end
      end else if (kind < 7) begin
        repeat ($urandom_range(4, 1)) begin
          send_pitch(sample_for_average(int'($urandom_range(18000))));
          sent++;
        end
      end else if (kind < 9) begin
        send_pitch(pitch_t'($urandom_range(65535)));
        sent++;
      end else begin
        repeat ($urandom_range(12, 3)) begin
          send_pitch('0);
          sent++;
        end
      end
    end
    wait_results_drained();
  endtask

  initial begin
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.pitch_estimate = '0;
    mismatch_count       = 0;
    cycle_count          = 0;
    send_idle_pct        = 0;
    recv_idle_pct        = 0;
    hold_cycles          = 0;
    pitch_sum            = '0;
    foreach (pitch_hist[i]) pitch_hist[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_band_edges();
    test_output_backpressure();
    test_random_tones(16, 75, 220);
    test_random_tones(75, 16, 220);
    test_random_tones(0, 0, 220);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_notes.size() != 0) begin
      $display("%0t results missing: %0d expected, 0 received", $time,
               expected_notes.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
